// ----- hdl/tcom_pkg.sv -----
// package for the track current overload monitor
// holds widths, codes, word types and the average update function
// no dependencies
`default_nettype none

package tcom_pkg;

  // fixed point format of the average
  localparam int ADC_BITS      = 10;
  localparam int FRACTION_BITS = 16;
  localparam int ACC_W         = ADC_BITS + FRACTION_BITS;

  // field widths
  localparam int ACTION_W  = 2;
  localparam int READING_W = 10;
  localparam int MODE_W    = 2;
  localparam int LEVEL_W   = 10;
  localparam int PERIOD_W  = 16;
  localparam int WEIGHT_W  = 16;
  localparam int TRIP_W    = 10;

  // bus widths
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // register reset values
  localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(10);
  localparam logic [WEIGHT_W-1:0] WEIGHT_RST = WEIGHT_W'(655);
  localparam logic [TRIP_W-1:0]   TRIP_RST   = TRIP_W'(300);

  localparam logic [PERIOD_W-1:0] COUNT_MAX = '1;
  localparam logic [LEVEL_W-1:0]  LEVEL_MAX = '1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_FACTOR = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_TRIP_LEVEL       = CFG_IDX_W'(2);

  localparam logic [ACTION_W-1:0] ACT_TICK      = ACTION_W'(0);
  localparam logic [ACTION_W-1:0] ACT_POWER_ON  = ACTION_W'(1);
  localparam logic [ACTION_W-1:0] ACT_POWER_OFF = ACTION_W'(2);

  localparam logic [MODE_W-1:0] MODE_OFF       = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_ON        = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_EMERGENCY = MODE_W'(2);

  typedef struct packed {
    logic [ACTION_W-1:0]  action;
    logic [READING_W-1:0] adc_value;
  } item_t;

  typedef struct packed {
    logic [MODE_W-1:0]  power_state;
    logic               track_enable;
    logic               sampled;
    logic               tripped;
    logic [LEVEL_W-1:0] smoothed_level;
  } result_t;

  localparam int PROD_W = ACC_W + 1 + WEIGHT_W + 1;

  // A' = A + floor((x*2^F - A) * a / 2^16), same as the two-product form
  function automatic logic [ACC_W-1:0] fold_sample(
    input logic [ACC_W-1:0]     acc,
    input logic [READING_W-1:0] reading,
    input logic [WEIGHT_W-1:0]  weight
  );
    logic signed [ACC_W:0]    x_fix;
    logic signed [ACC_W:0]    diff;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] step;
    logic signed [PROD_W-1:0] sum;
    x_fix = signed'((ACC_W + 1)'(reading) << FRACTION_BITS);
    diff  = x_fix - signed'({1'b0, acc});
    prod  = PROD_W'(diff) * PROD_W'(signed'({1'b0, weight}));
    step  = prod >>> WEIGHT_W;
    sum   = PROD_W'(signed'({1'b0, acc})) + step;
    return sum[ACC_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- hdl/tcom_in_reg.sv -----
// input register stage of the overload monitor
// depends on tcom_pkg
`default_nettype none

module tcom_in_reg (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           up_valid,
  output logic                up_ready,
  input  wire tcom_pkg::item_t up_item,
  input  wire logic           dn_advance,
  output logic                dn_valid,
  output tcom_pkg::item_t     dn_item
);

  logic            valid_r;
  logic            valid_nxt;
  tcom_pkg::item_t item_r;

  assign up_ready  = !valid_r || dn_advance;
  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      item_r <= up_item;
    end
  end

  assign dn_valid = valid_r;
  assign dn_item  = item_r;

endmodule

`default_nettype wire

// ----- hdl/tcom_core.sv -----
// monitor core: config registers, tick counter, average and power mode
// depends on tcom_pkg
`default_nettype none

module tcom_core (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_wr_en,
  input  wire logic [tcom_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [tcom_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire logic                               fire,
  input  wire tcom_pkg::item_t                    item,
  output tcom_pkg::result_t                       result
);

  logic [tcom_pkg::PERIOD_W-1:0] period_r;
  logic [tcom_pkg::WEIGHT_W-1:0] weight_r;
  logic [tcom_pkg::TRIP_W-1:0]   trip_r;

  logic [tcom_pkg::ACC_W-1:0]    acc_r,  acc_nxt;
  logic [tcom_pkg::PERIOD_W-1:0] cnt_r,  cnt_nxt;
  logic [tcom_pkg::MODE_W-1:0]   mode_r, mode_nxt;

  logic [tcom_pkg::PERIOD_W-1:0] cnt_inc;
  logic [tcom_pkg::ACC_W-1:0]    acc_fold;
  logic [tcom_pkg::ACC_W:0]      trip_fix;
  logic [tcom_pkg::ACC_W-1:0]    level_full;
  logic                          sampled;
  logic                          tripped;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= tcom_pkg::PERIOD_RST;
      weight_r <= tcom_pkg::WEIGHT_RST;
      trip_r   <= tcom_pkg::TRIP_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        tcom_pkg::REG_SAMPLE_PERIOD:    period_r <= cfg_wdata[tcom_pkg::PERIOD_W-1:0];
        tcom_pkg::REG_SMOOTHING_FACTOR: weight_r <= cfg_wdata[tcom_pkg::WEIGHT_W-1:0];
        tcom_pkg::REG_TRIP_LEVEL:       trip_r   <= cfg_wdata[tcom_pkg::TRIP_W-1:0];
        default: ;
      endcase
    end
  end

  assign cnt_inc  = (cnt_r != tcom_pkg::COUNT_MAX) ? cnt_r + 1'b1 : cnt_r;
  assign acc_fold = tcom_pkg::fold_sample(acc_r, item.adc_value, weight_r);
  assign trip_fix = (tcom_pkg::ACC_W + 1)'(trip_r) << tcom_pkg::FRACTION_BITS;

  always_comb begin
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    mode_nxt = mode_r;
    sampled  = 1'b0;
    tripped  = 1'b0;
    unique case (item.action)
      tcom_pkg::ACT_TICK: begin
        cnt_nxt = cnt_inc;
        if (cnt_inc >= period_r) begin
          cnt_nxt = '0;
          acc_nxt = acc_fold;
          sampled = 1'b1;
          if (mode_r == tcom_pkg::MODE_ON && {1'b0, acc_fold} > trip_fix) begin
            mode_nxt = tcom_pkg::MODE_EMERGENCY;
            tripped  = 1'b1;
          end
        end
      end
      tcom_pkg::ACT_POWER_ON:  mode_nxt = tcom_pkg::MODE_ON;
      tcom_pkg::ACT_POWER_OFF: mode_nxt = tcom_pkg::MODE_OFF;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      cnt_r  <= '0;
      mode_r <= tcom_pkg::MODE_OFF;
    end else if (fire) begin
      acc_r  <= acc_nxt;
      cnt_r  <= cnt_nxt;
      mode_r <= mode_nxt;
    end
  end

  assign level_full = acc_nxt >> tcom_pkg::FRACTION_BITS;

  always_comb begin
    result.power_state  = mode_nxt;
    result.track_enable = (mode_nxt == tcom_pkg::MODE_ON);
    result.sampled      = sampled;
    result.tripped      = tripped;
    result.smoothed_level = (level_full > tcom_pkg::ACC_W'(tcom_pkg::LEVEL_MAX)) ?
                            tcom_pkg::LEVEL_MAX : level_full[tcom_pkg::LEVEL_W-1:0];
  end

endmodule

`default_nettype wire

// ----- hdl/tcom_out_reg.sv -----
// result register stage of the overload monitor
// depends on tcom_pkg
`default_nettype none

module tcom_out_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              up_valid,
  output logic                   up_advance,
  input  wire tcom_pkg::result_t up_result,
  output logic                   dn_valid,
  input  wire logic              dn_ready,
  output tcom_pkg::result_t      dn_result
);

  logic              valid_r;
  logic              valid_nxt;
  tcom_pkg::result_t result_r;

  assign up_advance = !valid_r || dn_ready;
  assign valid_nxt  = up_advance ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_advance && up_valid) begin
      result_r <= up_result;
    end
  end

  assign dn_valid  = valid_r;
  assign dn_result = result_r;

endmodule

`default_nettype wire

// ----- hdl/track_current_overload_monitor.sv -----
// top level of the track current overload monitor
// depends on tcom_pkg, tcom_in_reg, tcom_core, tcom_out_reg
//
// usage:
//   in_*  stream: one word per event; in_tuser is the action (tick with a
//         current sample, power on, power off), in_tdata the converter reading
//   out_* stream: exactly one result word per input word, in order
//   cfg_* write port: sample period, smoothing factor and trip level, written
//         while the block is idle; unknown indexes are ignored
// path: an accepted word is held in the input register, then its result in the result register, which drives out_tvalid
// throughput: one word per cycle while out_tready is high; the average update
//   (one subtract, one 27x17 multiply and one add) sits between the input
//   register and the result register
// reset (rst_n low, synchronous): both stages empty, power off, average and
//   tick counter zero, registers back to their defaults
// receiver stall: the result register holds its word; the input register takes
//   one more word if it is empty, then in_tready drops until out_tready returns
`default_nettype none

module track_current_overload_monitor (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // input stream
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [tcom_pkg::IN_DATA_W-1:0]     in_tdata,  // [9:0] adc_value, rest zero
  input  wire logic [tcom_pkg::ACTION_W-1:0]      in_tuser,  // [1:0] action
  // result stream
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // [1:0] power_state, [2] track_enable, [3] sampled, [4] tripped,
  // [14:5] smoothed_level, [15] zero
  output logic [tcom_pkg::OUT_DATA_W-1:0]         out_tdata,
  // configuration writes
  input  wire logic                               cfg_wr_en,
  input  wire logic [tcom_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [tcom_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  tcom_pkg::item_t   in_item;
  tcom_pkg::item_t   stage_item;
  tcom_pkg::result_t core_result;
  tcom_pkg::result_t out_result;
  logic              stage_valid;
  logic              stage_advance;
  logic              fire;

  // unpack the incoming word
  assign in_item.action    = in_tuser;
  assign in_item.adc_value = in_tdata[tcom_pkg::READING_W-1:0];

  tcom_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (in_tvalid),
    .up_ready   (in_tready),
    .up_item    (in_item),
    .dn_advance (stage_advance),
    .dn_valid   (stage_valid),
    .dn_item    (stage_item)
  );

  // state moves only when the registered item passes into the result stage
  assign fire = stage_valid && stage_advance;

  tcom_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .item      (stage_item),
    .result    (core_result)
  );

  tcom_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (stage_valid),
    .up_advance (stage_advance),
    .up_result  (core_result),
    .dn_valid   (out_tvalid),
    .dn_ready   (out_tready),
    .dn_result  (out_result)
  );

  // pack the result word, power state in the lowest bits
  assign out_tdata = tcom_pkg::OUT_DATA_W'({out_result.smoothed_level,
                                            out_result.tripped,
                                            out_result.sampled,
                                            out_result.track_enable,
                                            out_result.power_state});

endmodule

`default_nettype wire

// ----- hdl/tcom_checker.sv -----
// port-level checks for the track current overload monitor, bound to the top
// depends on tcom_pkg and track_current_overload_monitor
`default_nettype none

module tcom_port_checks (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [tcom_pkg::OUT_DATA_W-1:0] out_tdata
);

  logic [tcom_pkg::MODE_W-1:0] state_w;
  logic                        enable_w;
  logic                        sampled_w;
  logic                        tripped_w;

  assign state_w   = out_tdata[tcom_pkg::MODE_W-1:0];
  assign enable_w  = out_tdata[tcom_pkg::MODE_W];
  assign sampled_w = out_tdata[tcom_pkg::MODE_W+1];
  assign tripped_w = out_tdata[tcom_pkg::MODE_W+2];

  // pipeline empty after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // track enable follows the power state
  a_enable_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (enable_w == (state_w == tcom_pkg::MODE_ON)))
    else $error("track enable does not match power state");

  // a trip only comes from a sample and leaves the block in emergency
  a_trip_sampled: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && tripped_w |-> sampled_w && state_w == tcom_pkg::MODE_EMERGENCY)
    else $error("trip without sample or without emergency state");

  // stalled result word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

endmodule

bind track_current_overload_monitor tcom_port_checks u_tcom_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
